// ===== rtl/particle_swarm_poly_fit_defines.svh =====
// Assertion macros shared by the RTL files.
// Each macro assumes a clock named clk and an active-low reset named rst_n.
`ifndef PARTICLE_SWARM_POLY_FIT_DEFINES_SVH
`define PARTICLE_SWARM_POLY_FIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a condition holds at every clock edge outside reset.
`define PSF_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// Check that a condition holds in the cycle after a trigger.
`define PSF_ASSERT_NEXT(lbl, trig, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (expr)) \
        else $error(msg);
`else
`define PSF_ASSERT(lbl, expr, msg)
`define PSF_ASSERT_NEXT(lbl, trig, expr, msg)
`endif

`endif

// ===== rtl/psf_pkg.sv =====
`default_nettype none
package psf_pkg;

    localparam int PARTICLES_DEF = 512;
    localparam int SAMPLES_DEF   = 32;
    localparam int DIMENSIONS    = 6;
    localparam int CMDQ_DEPTH    = 2;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_INIT   = 2'd1;
    localparam logic [1:0] MODE_UPDATE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] CFG_COGNITIVE = 3'd0;
    localparam logic [2:0] CFG_SOCIAL    = 3'd1;
    localparam logic [2:0] CFG_VLIMIT    = 3'd2;
    localparam logic [2:0] CFG_PLIMIT    = 3'd3;
    localparam logic [2:0] CFG_SAMPLES   = 3'd4;

    localparam logic [2:0] LAST_DIM = 3'(DIMENSIONS - 1);

    typedef struct packed {
        logic [1:0]         mode;
        logic [8:0]         particle_index;
        logic [2:0]         dimension_index;
        logic [4:0]         sample_index;
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
        logic [15:0]        inertia_weight;
        logic [15:0]        random_personal;
        logic [15:0]        random_global;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         coordinate_index;
        logic signed [31:0] global_coordinate;
        logic [63:0]        particle_error;
        logic [63:0]        global_best_error;
        logic               personal_improved;
        logic               global_improved;
        logic               last_result;
    } out_item_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        in_item_t item;
        logic     scores;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage
`default_nettype wire

// ===== rtl/psf_front.sv =====
`default_nettype none
module psf_front #(
    parameter int PARTICLES = 512,
    parameter int SAMPLES   = 32
) (
    input  wire logic             push,
    input  wire psf_pkg::in_item_t item,
    output logic                  full,
    input  wire psf_pkg::q_status_t q_status,
    output logic                  q_push,
    output psf_pkg::cmd_t         q_cmd
);
    import psf_pkg::*;

    logic keep;

    // Drop unused modes and out-of-range indices here.
    always_comb
    begin
        unique case (item.mode)
            MODE_LOAD:   keep = 32'(item.sample_index) < SAMPLES;
            MODE_INIT,
            MODE_UPDATE: keep = (32'(item.particle_index) < PARTICLES)
                                && (item.dimension_index <= LAST_DIM);
            default:     keep = 1'b0;
        endcase
    end

    assign full         = q_status.full;
    assign q_push       = push && !q_status.full && keep;
    assign q_cmd.item   = item;
    assign q_cmd.scores = (item.mode != MODE_LOAD) && (item.dimension_index == LAST_DIM);

endmodule
`default_nettype wire

// ===== rtl/psf_cmd_queue.sv =====
`default_nettype none
`include "particle_swarm_poly_fit_defines.svh"
module psf_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_push,
    input  wire psf_pkg::cmd_t q_cmd,
    input  wire logic          q_pop,
    output psf_pkg::cmd_t      q_head,
    output psf_pkg::q_status_t q_status
);
    import psf_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t          entry_reg [CMDQ_DEPTH];
    logic [PW-1:0] wptr_reg, wptr_next;
    logic [PW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == CW'(CMDQ_DEPTH));
    assign do_push = q_push && !q_status.full;
    assign do_pop  = q_pop && !q_status.empty;
    assign q_head  = entry_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = do_push ? PW'(32'(wptr_reg) + 1) : wptr_reg;
        rptr_next  = do_pop ? PW'(32'(rptr_reg) + 1) : rptr_reg;
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= q_cmd;
        end
    end

    `PSF_ASSERT(a_q_count_bound, count_reg <= CW'(CMDQ_DEPTH), "command queue overfilled")

endmodule
`default_nettype wire

// ===== rtl/psf_back.sv =====
`default_nettype none
`include "particle_swarm_poly_fit_defines.svh"
module psf_back #(
    parameter int PARTICLES = 512,
    parameter int SAMPLES   = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire psf_pkg::q_status_t q_status,
    input  wire psf_pkg::cmd_t      q_head,
    output logic                    q_pop,
    input  wire logic               pop,
    output logic                    empty,
    output psf_pkg::out_item_t      result
);
    import psf_pkg::*;

    localparam int DEPTH = PARTICLES * DIMENSIONS;
    localparam int PA_W  = $clog2(DEPTH);
    localparam int PI_W  = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int SA_W  = $clog2(SAMPLES);
    localparam int NW    = $clog2(SAMPLES + 1);

    typedef enum logic [22:0] {
        ST_IDLE = 23'h000001, ST_DISP = 23'h000002, ST_U_G1 = 23'h000004,
        ST_U_G2 = 23'h000008, ST_U_WV = 23'h000010, ST_U_P1 = 23'h000020,
        ST_U_P2 = 23'h000040, ST_U_V  = 23'h000080, ST_U_WR = 23'h000100,
        ST_L_A  = 23'h000200, ST_L_W  = 23'h000400, ST_L_D  = 23'h000800,
        ST_S_SA = 23'h001000, ST_S_SW = 23'h002000, ST_S_HM = 23'h004000,
        ST_S_HA = 23'h008000, ST_S_RM = 23'h010000, ST_S_RA = 23'h020000,
        ST_BEST = 23'h040000, ST_GB   = 23'h080000, ST_PW   = 23'h100000,
        ST_OUT  = 23'h200000, ST_DONE = 23'h400000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [15:0] cog_reg, soc_reg;
    logic [30:0] vlim_reg, plim_reg;
    logic [5:0]  scnt_reg;

    // memories
    logic signed [31:0] pos_mem [DEPTH];
    logic signed [31:0] vel_mem [DEPTH];
    logic signed [31:0] pb_mem  [DEPTH];
    logic [63:0]        pbe_mem [PARTICLES];
    logic signed [31:0] sx_mem  [SAMPLES];
    logic signed [31:0] sy_mem  [SAMPLES];
    logic signed [31:0] pos_rd, vel_rd, pb_rd, sx_rd, sy_rd;
    logic [63:0]        pbe_rd;

    cmd_t               cmd_reg;
    logic [PA_W-1:0]    mem_addr_reg, base_reg, pb_waddr;
    logic [SA_W-1:0]    s_addr_reg;
    logic [2:0]         cnt_reg;
    logic [NW-1:0]      i_reg, n_samples;
    logic signed [31:0] pos_reg, vel_reg, pbp_reg, vnew_reg, acc_reg;
    logic [15:0]        g1_reg, g2_reg;
    logic signed [47:0] vacc_reg;
    logic signed [67:0] prod_reg;
    logic signed [33:0] ma, mb;
    logic signed [31:0] coef_reg [DIMENSIONS];
    logic signed [31:0] pbuf_reg [DIMENSIONS];
    logic signed [31:0] gb_reg   [DIMENSIONS];
    logic [63:0]        sum_reg, gbe_reg, pbe_new_reg;
    logic               pimp_reg, gimp_reg;
    out_item_t          out_reg;
    logic               out_valid_reg;

    logic [2:0]         gb_idx;
    logic signed [31:0] gb_sel;
    logic [PA_W-1:0]    head_base;
    logic signed [48:0] horner_sum;
    logic signed [31:0] horner_sat;
    logic signed [32:0] resid;
    logic signed [47:0] vsum, vlim48;
    logic signed [31:0] vclamp, pclamp;
    logic signed [32:0] psum, plim33;
    logic [64:0]        sum_wide;
    logic               emit;

    assign n_samples = (32'(scnt_reg) > SAMPLES) ? NW'(SAMPLES) : NW'(scnt_reg);
    assign head_base = PA_W'(PA_W'(q_head.item.particle_index) * PA_W'(DIMENSIONS));
    assign gb_idx    = (state_reg == ST_OUT) ? cnt_reg : cmd_reg.item.dimension_index;
    assign gb_sel    = gb_reg[gb_idx];
    assign q_pop     = (state_reg == ST_IDLE) && !q_status.empty;
    assign emit      = (state_reg == ST_OUT) && (!out_valid_reg || pop);
    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign pb_waddr  = (state_reg == ST_PW) ? base_reg + PA_W'(cnt_reg) : mem_addr_reg;

    // Shared multiplier operands.
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (state_reg)
            ST_U_G1: begin ma = 34'(cog_reg); mb = 34'(cmd_reg.item.random_personal); end
            ST_U_G2: begin ma = 34'(soc_reg); mb = 34'(cmd_reg.item.random_global); end
            ST_U_WV: begin ma = 34'(cmd_reg.item.inertia_weight); mb = 34'(vel_reg); end
            ST_U_P1: begin ma = 34'(pbp_reg) - 34'(pos_reg); mb = 34'(g1_reg); end
            ST_U_P2: begin ma = 34'(gb_sel) - 34'(pos_reg); mb = 34'(g2_reg); end
            ST_S_HM: begin ma = 34'(acc_reg); mb = 34'(sx_rd); end
            ST_S_RM: begin ma = 34'(resid); mb = 34'(resid); end
            default: begin ma = '0; mb = '0; end
        endcase
    end

    always_comb
    begin
        resid      = 33'(sy_rd) - 33'(acc_reg);
        horner_sum = 49'($signed(prod_reg[63:16])) + 49'(coef_reg[cnt_reg]);
        if (horner_sum > 49'sd2147483647)
            horner_sat = 32'sh7fffffff;
        else if (horner_sum < -49'sd2147483648)
            horner_sat = 32'sh80000000;
        else
            horner_sat = horner_sum[31:0];
        vsum   = vacc_reg + prod_reg[59:12];
        vlim48 = 48'(vlim_reg);
        if (vsum > vlim48)
            vclamp = 32'(vlim_reg);
        else if (vsum < -vlim48)
            vclamp = -32'(vlim_reg);
        else
            vclamp = vsum[31:0];
        psum   = 33'(pos_reg) + 33'(vnew_reg);
        plim33 = 33'(plim_reg);
        if (psum > plim33)
            pclamp = 32'(plim_reg);
        else if (psum < -plim33)
            pclamp = -32'(plim_reg);
        else
            pclamp = psum[31:0];
        sum_wide = {1'b0, sum_reg} + 65'(prod_reg[63:16]);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!q_status.empty) state_next = ST_DISP;
            ST_DISP:
            begin
                if (cmd_reg.item.mode == MODE_UPDATE)
                    state_next = ST_U_G1;
                else if (cmd_reg.scores)
                    state_next = ST_L_A;
                else
                    state_next = ST_IDLE;
            end
            ST_U_G1: state_next = ST_U_G2;
            ST_U_G2: state_next = ST_U_WV;
            ST_U_WV: state_next = ST_U_P1;
            ST_U_P1: state_next = ST_U_P2;
            ST_U_P2: state_next = ST_U_V;
            ST_U_V:  state_next = ST_U_WR;
            ST_U_WR: state_next = cmd_reg.scores ? ST_L_A : ST_IDLE;
            ST_L_A:  state_next = ST_L_W;
            ST_L_W:  state_next = ST_L_D;
            ST_L_D:
            begin
                if (cnt_reg != LAST_DIM)
                    state_next = ST_L_A;
                else if (n_samples == '0)
                    state_next = ST_BEST;
                else
                    state_next = ST_S_SA;
            end
            ST_S_SA: state_next = ST_S_SW;
            ST_S_SW: state_next = ST_S_HM;
            ST_S_HM: state_next = ST_S_HA;
            ST_S_HA: state_next = (cnt_reg == 3'd0) ? ST_S_RM : ST_S_HM;
            ST_S_RM: state_next = ST_S_RA;
            ST_S_RA: state_next = (i_reg + NW'(1) == n_samples) ? ST_BEST : ST_S_SA;
            ST_BEST: state_next = ST_GB;
            ST_GB:   state_next = pimp_reg ? ST_PW : ST_OUT;
            ST_PW:   state_next = (cnt_reg == LAST_DIM) ? ST_OUT : ST_PW;
            ST_OUT:  if (emit && cnt_reg == LAST_DIM) state_next = ST_DONE;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cog_reg       <= 16'd8192;
            soc_reg       <= 16'd3277;
            vlim_reg      <= 31'd1966080;
            plim_reg      <= 31'd19660800;
            scnt_reg      <= 6'd21;
            gbe_reg       <= '1;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < DIMENSIONS; k++)
                gb_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_COGNITIVE: cog_reg  <= cfg_data[15:0];
                    CFG_SOCIAL:    soc_reg  <= cfg_data[15:0];
                    CFG_VLIMIT:    vlim_reg <= cfg_data[30:0];
                    CFG_PLIMIT:    plim_reg <= cfg_data[30:0];
                    CFG_SAMPLES:   scnt_reg <= cfg_data[5:0];
                    default:       ;
                endcase
            end
            if (state_reg == ST_GB && pbe_new_reg < gbe_reg)
            begin
                gbe_reg <= pbe_new_reg;
                for (int k = 0; k < DIMENSIONS; k++)
                    gb_reg[k] <= pimp_reg ? coef_reg[k] : pbuf_reg[k];
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_reg      <= q_head;
                base_reg     <= head_base;
                mem_addr_reg <= head_base + PA_W'(q_head.item.dimension_index);
                cnt_reg      <= '0;
            end
            ST_U_G1:
            begin
                pos_reg <= pos_rd;
                vel_reg <= vel_rd;
                pbp_reg <= pb_rd;
            end
            ST_U_G2: g1_reg   <= prod_reg[31:16];
            ST_U_WV: g2_reg   <= prod_reg[31:16];
            ST_U_P1: vacc_reg <= prod_reg[63:16];
            ST_U_P2: vacc_reg <= vacc_reg + prod_reg[59:12];
            ST_U_V:  vnew_reg <= vclamp;
            ST_L_A:  mem_addr_reg <= base_reg + PA_W'(cnt_reg);
            ST_L_D:
            begin
                coef_reg[cnt_reg] <= pos_rd;
                pbuf_reg[cnt_reg] <= pb_rd;
                cnt_reg           <= (cnt_reg == LAST_DIM) ? 3'd0 : cnt_reg + 3'd1;
                i_reg             <= '0;
                sum_reg           <= '0;
            end
            ST_S_SA: s_addr_reg <= i_reg[SA_W-1:0];
            ST_S_SW:
            begin
                acc_reg <= coef_reg[DIMENSIONS-1];
                cnt_reg <= 3'(DIMENSIONS - 2);
            end
            ST_S_HA:
            begin
                acc_reg <= horner_sat;
                if (cnt_reg != 3'd0)
                    cnt_reg <= cnt_reg - 3'd1;
            end
            ST_S_RA:
            begin
                sum_reg <= sum_wide[64] ? '1 : sum_wide[63:0];
                i_reg   <= i_reg + NW'(1);
            end
            ST_BEST:
            begin
                if (cmd_reg.item.mode == MODE_INIT || sum_reg < pbe_rd)
                begin
                    pimp_reg    <= 1'b1;
                    pbe_new_reg <= sum_reg;
                end
                else
                begin
                    pimp_reg    <= 1'b0;
                    pbe_new_reg <= pbe_rd;
                end
                cnt_reg <= '0;
            end
            ST_GB:   gimp_reg <= pbe_new_reg < gbe_reg;
            ST_PW:   cnt_reg  <= (cnt_reg == LAST_DIM) ? 3'd0 : cnt_reg + 3'd1;
            ST_OUT:  if (emit) cnt_reg <= cnt_reg + 3'd1;
            default: ;
        endcase
        if (emit)
        begin
            out_reg.coordinate_index  <= cnt_reg;
            out_reg.global_coordinate <= gb_sel;
            out_reg.particle_error    <= sum_reg;
            out_reg.global_best_error <= gbe_reg;
            out_reg.personal_improved <= pimp_reg;
            out_reg.global_improved   <= gimp_reg;
            out_reg.last_result       <= (cnt_reg == LAST_DIM);
        end
    end

    // Particle memories: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DISP && cmd_reg.item.mode == MODE_INIT) || state_reg == ST_U_WR)
        begin
            pos_mem[mem_addr_reg] <= (state_reg == ST_U_WR) ? pclamp
                                                            : cmd_reg.item.first_value;
            vel_mem[mem_addr_reg] <= (state_reg == ST_U_WR) ? vnew_reg
                                                            : cmd_reg.item.second_value;
        end
        pos_rd <= pos_mem[mem_addr_reg];
        vel_rd <= vel_mem[mem_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DISP && cmd_reg.item.mode == MODE_INIT)
            pb_mem[pb_waddr] <= cmd_reg.item.first_value;
        else if (state_reg == ST_PW)
            pb_mem[pb_waddr] <= coef_reg[cnt_reg];
        pb_rd <= pb_mem[mem_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_BEST && (cmd_reg.item.mode == MODE_INIT || sum_reg < pbe_rd))
            pbe_mem[PI_W'(cmd_reg.item.particle_index)] <= sum_reg;
        pbe_rd <= pbe_mem[PI_W'(cmd_reg.item.particle_index)];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DISP && cmd_reg.item.mode == MODE_LOAD)
        begin
            sx_mem[SA_W'(cmd_reg.item.sample_index)] <= cmd_reg.item.first_value;
            sy_mem[SA_W'(cmd_reg.item.sample_index)] <= cmd_reg.item.second_value;
        end
        sx_rd <= sx_mem[s_addr_reg];
        sy_rd <= sy_mem[s_addr_reg];
    end

    `PSF_ASSERT(a_gbe_never_rises, gbe_reg <= $past(gbe_reg), "global best error rose")
    `PSF_ASSERT_NEXT(a_emit_fills, emit, out_valid_reg, "emitted beat not held")
    `PSF_ASSERT(a_last_is_top, !out_valid_reg || !out_reg.last_result || out_reg.coordinate_index == LAST_DIM, "last beat on wrong coordinate")

endmodule
`default_nettype wire

// ===== rtl/particle_swarm_poly_fit.sv =====
// Channel   | Handshake            | Payload
// ----------+----------------------+---------------------------------------
// input     | push / full          | item   (psf_pkg::in_item_t)
// result    | pop / empty          | result (psf_pkg::out_item_t)
// config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Loads and plain inits write at dispatch; a coordinate update uses the one shared multiplier.
// Scoring fetches the coefficients, runs Horner steps and a squared residual per sample,
// compares, rewrites an improved personal best, then gives one result beat per coordinate.
// Reset clears control, loads the default configuration and the global best; the
// particle and sample stores need no clearing. A stalled result side holds the
// back end, while the front keeps taking items until the command queue fills.
`default_nettype none
module particle_swarm_poly_fit #(
    parameter int PARTICLES = psf_pkg::PARTICLES_DEF,
    parameter int SAMPLES   = psf_pkg::SAMPLES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire psf_pkg::in_item_t item,
    output logic                   empty,
    input  wire logic              pop,
    output psf_pkg::out_item_t     result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [31:0]       cfg_data
);
    import psf_pkg::*;

    q_status_t q_status;
    logic      q_push, q_pop;
    cmd_t      q_cmd, q_head;

    // Configuration is always taken; the sender must write only while nothing is in flight (not enforced here).
    assign cfg_ready = 1'b1;

    // Classify and drop bad items.
    psf_front #(
        .PARTICLES(PARTICLES),
        .SAMPLES  (SAMPLES)
    ) u_front (
        .push    (push),
        .item    (item),
        .full    (full),
        .q_status(q_status),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    // Decouple the front from the sequencer.
    psf_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_status(q_status)
    );

    // Execute: memories, shared multiplier, scoring and result beats.
    psf_back #(
        .PARTICLES(PARTICLES),
        .SAMPLES  (SAMPLES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .q_status (q_status),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

endmodule
`default_nettype wire
